/* src/tcps_pkg.sv */
// tcps_pkg: shared widths, register indexes, reset values and result codes
// for the touch calibration and pen state block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tcps_pkg;

    // field and register widths
    localparam int RAW_W   = 15;
    localparam int COEF_W  = 32;
    localparam int TICK_W  = 16;
    localparam int POS_W   = 8;
    localparam int KIND_W  = 2;
    localparam int CIDX_W  = 4;
    localparam int OPND_W  = RAW_W + 1;

    // numerator width: offset plus two 32 x 15 products fits 48 bits signed
    localparam int NUM_W   = 48;
    // magnitude of any numerator stays below 2^47
    localparam int MAG_W   = 47;

    // result codes
    typedef enum logic [KIND_W-1:0] {
        KIND_PRESS    = 2'd0,
        KIND_POSITION = 2'd1,
        KIND_RELEASE  = 2'd2
    } kind_t;

    // input opcodes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_COEF_X_FROM_X = 4'd0;
    localparam logic [CIDX_W-1:0] CFG_COEF_X_FROM_Y = 4'd1;
    localparam logic [CIDX_W-1:0] CFG_OFFSET_X      = 4'd2;
    localparam logic [CIDX_W-1:0] CFG_COEF_Y_FROM_X = 4'd3;
    localparam logic [CIDX_W-1:0] CFG_COEF_Y_FROM_Y = 4'd4;
    localparam logic [CIDX_W-1:0] CFG_OFFSET_Y      = 4'd5;
    localparam logic [CIDX_W-1:0] CFG_SCALE_DIVISOR = 4'd6;
    localparam logic [CIDX_W-1:0] CFG_RELEASE_TICKS = 4'd7;

    // register reset values
    localparam logic signed [COEF_W-1:0] COEF_ONE     = 32'sd1;
    localparam logic signed [COEF_W-1:0] COEF_ZERO    = 32'sd0;
    localparam logic [TICK_W-1:0]        RELEASE_INIT = 16'd15;

    // idle tick counter saturates here
    localparam logic [TICK_W-1:0] TICK_MAX = 16'hFFFF;

endpackage : tcps_pkg

`default_nettype wire

/* src/touch_calibrate_and_pen_state.sv */
// touch_calibrate_and_pen_state: pen state tracking and affine calibration
// of touch samples; multiply-accumulate sequencer around a shared divider
// depends on tcps_pkg and tcps_div
//
// Usage: the input channel carries touch samples (opcode 0 with raw x, y,
// z1) and 10 ms ticks (opcode 1). A transfer happens on a rising edge with
// valid high and stall low, on both channels. At most one result leaves per
// input item: pen press, position report or pen release.
// Ticks, press samples and samples that give no result are answered, when
// they give a result, in the cycle after the transfer.
// A position report is built by one 32 x 16 multiplier, used twice per axis,
// and one 47-step restoring divider, used once per axis; the x pass and then
// the y pass run through them, and the output register is loaded after the
// y pass. The input stalls while that runs. A zero divisor skips the
// arithmetic and reports at once with divide_error set. Configuration is
// written through cfg_we, cfg_index, cfg_data while idle, a rule for the
// user that the block does not check; indexes above 7 are ignored.
// Reset loads the register defaults (identity map, release after 15 ticks),
// pen up, no result pending. While the receiver stalls, the result is held
// in the output register and no input that could give a result is taken.
`timescale 1ns / 1ps
`default_nettype none

module touch_calibrate_and_pen_state (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write port
    input  logic                                cfg_we,
    input  logic [tcps_pkg::CIDX_W-1:0]         cfg_index,
    input  logic [tcps_pkg::COEF_W-1:0]         cfg_data,
    // input channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                opcode,
    input  logic [tcps_pkg::RAW_W-1:0]          raw_x,
    input  logic [tcps_pkg::RAW_W-1:0]          raw_y,
    input  logic [tcps_pkg::RAW_W-1:0]          raw_z1,
    // result channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [tcps_pkg::KIND_W-1:0]         event_kind,
    output logic [tcps_pkg::POS_W-1:0]          pos_x,
    output logic [tcps_pkg::POS_W-1:0]          pos_y,
    output logic                                divide_error
);
    import tcps_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_A,
        S_MUL_B,
        S_ADD,
        S_START,
        S_WAIT,
        S_OUT
    } state_t;

    // configuration registers
    logic signed [COEF_W-1:0] cxx_reg;
    logic signed [COEF_W-1:0] cxy_reg;
    logic signed [COEF_W-1:0] ox_reg;
    logic signed [COEF_W-1:0] cyx_reg;
    logic signed [COEF_W-1:0] cyy_reg;
    logic signed [COEF_W-1:0] oy_reg;
    logic signed [COEF_W-1:0] div_reg;
    logic        [TICK_W-1:0] rel_reg;

    // pen state
    state_t                   state_reg;
    logic                     pen_reg;
    logic                     first_reg;
    logic        [TICK_W-1:0] cnt_reg;

    // datapath
    logic                     pass_reg;
    logic        [RAW_W-1:0]  x_reg;
    logic        [RAW_W-1:0]  y_reg;
    logic signed [NUM_W-1:0]  prod_reg;
    logic signed [NUM_W-1:0]  acc_reg;
    logic        [POS_W-1:0]  qx_reg;

    // result register
    logic                     ovalid_reg;
    kind_t                    kind_reg;
    logic        [POS_W-1:0]  px_reg;
    logic        [POS_W-1:0]  py_reg;
    logic                     err_reg;

    logic                     in_xfer;
    logic                     out_free;
    logic        [TICK_W-1:0] cnt_inc;
    logic signed [COEF_W-1:0] coef_a;
    logic signed [COEF_W-1:0] coef_b;
    logic signed [COEF_W-1:0] offset;
    logic signed [COEF_W-1:0] mul_c;
    logic signed [OPND_W-1:0] mul_r;
    logic signed [NUM_W-1:0]  mul_p;
    logic                     div_start;
    logic                     div_done;
    logic        [POS_W-1:0]  div_quot;

    // handshake
    assign out_free = !ovalid_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE) || !out_free;
    assign in_xfer  = in_valid && !in_stall;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cxx_reg <= COEF_ONE;
            cxy_reg <= COEF_ZERO;
            ox_reg  <= COEF_ZERO;
            cyx_reg <= COEF_ZERO;
            cyy_reg <= COEF_ONE;
            oy_reg  <= COEF_ZERO;
            div_reg <= COEF_ONE;
            rel_reg <= RELEASE_INIT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_COEF_X_FROM_X: cxx_reg <= cfg_data;
                CFG_COEF_X_FROM_Y: cxy_reg <= cfg_data;
                CFG_OFFSET_X:      ox_reg  <= cfg_data;
                CFG_COEF_Y_FROM_X: cyx_reg <= cfg_data;
                CFG_COEF_Y_FROM_Y: cyy_reg <= cfg_data;
                CFG_OFFSET_Y:      oy_reg  <= cfg_data;
                CFG_SCALE_DIVISOR: div_reg <= cfg_data;
                CFG_RELEASE_TICKS: rel_reg <= cfg_data[TICK_W-1:0];
                default:           ;
            endcase
        end
    end

    // saturating idle tick count
    assign cnt_inc = (cnt_reg == TICK_MAX) ? cnt_reg : cnt_reg + 1'b1;

    // coefficient select for the current axis
    assign coef_a = pass_reg ? cyx_reg : cxx_reg;
    assign coef_b = pass_reg ? cyy_reg : cxy_reg;
    assign offset = pass_reg ? oy_reg  : ox_reg;

    // shared multiplier
    assign mul_c = (state_reg == S_MUL_A) ? coef_a : coef_b;
    assign mul_r = (state_reg == S_MUL_A) ? OPND_W'({1'b0, x_reg})
                                          : OPND_W'({1'b0, y_reg});
    assign mul_p = mul_c * mul_r;

    assign div_start = (state_reg == S_START);

    tcps_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (acc_reg),
        .den   (div_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    // multiply-accumulate datapath
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            x_reg <= raw_x;
            y_reg <= raw_y;
        end
        unique case (state_reg)
            S_MUL_A:
            begin
                prod_reg <= mul_p;
                acc_reg  <= NUM_W'(offset);
            end
            S_MUL_B:
            begin
                prod_reg <= mul_p;
                acc_reg  <= acc_reg + prod_reg;
            end
            S_ADD:
            begin
                acc_reg <= acc_reg + prod_reg;
            end
            default: ;
        endcase
    end

    // sequencer, pen state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            pen_reg    <= 1'b0;
            first_reg  <= 1'b1;
            cnt_reg    <= '0;
            pass_reg   <= 1'b0;
            qx_reg     <= '0;
            ovalid_reg <= 1'b0;
            kind_reg   <= KIND_PRESS;
            px_reg     <= '0;
            py_reg     <= '0;
            err_reg    <= 1'b0;
        end
        else
        begin
            // result leaves on transfer
            if (ovalid_reg && !out_stall)
            begin
                ovalid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        if (opcode == OP_TICK)
                        begin
                            // ticks only count with the pen down
                            if (pen_reg)
                            begin
                                if (cnt_inc >= rel_reg)
                                begin
                                    pen_reg    <= 1'b0;
                                    first_reg  <= 1'b1;
                                    cnt_reg    <= '0;
                                    ovalid_reg <= 1'b1;
                                    kind_reg   <= KIND_RELEASE;
                                    px_reg     <= '0;
                                    py_reg     <= '0;
                                    err_reg    <= 1'b0;
                                end
                                else
                                begin
                                    cnt_reg <= cnt_inc;
                                end
                            end
                        end
                        else
                        begin
                            cnt_reg <= '0;
                            if (!pen_reg)
                            begin
                                // press: coordinates dropped
                                pen_reg    <= 1'b1;
                                ovalid_reg <= 1'b1;
                                kind_reg   <= KIND_PRESS;
                                px_reg     <= '0;
                                py_reg     <= '0;
                                err_reg    <= 1'b0;
                            end
                            else
                            begin
                                first_reg <= 1'b0;
                                if ((raw_z1 != '0) || first_reg)
                                begin
                                    if (div_reg == '0)
                                    begin
                                        // zero divisor reports at once
                                        ovalid_reg <= 1'b1;
                                        kind_reg   <= KIND_POSITION;
                                        px_reg     <= '0;
                                        py_reg     <= '0;
                                        err_reg    <= 1'b1;
                                    end
                                    else
                                    begin
                                        pass_reg  <= 1'b0;
                                        state_reg <= S_MUL_A;
                                    end
                                end
                            end
                        end
                    end
                end
                S_MUL_A:
                begin
                    state_reg <= S_MUL_B;
                end
                S_MUL_B:
                begin
                    state_reg <= S_ADD;
                end
                S_ADD:
                begin
                    state_reg <= S_START;
                end
                S_START:
                begin
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    // x pass then y pass through the shared divider
                    if (div_done)
                    begin
                        if (!pass_reg)
                        begin
                            qx_reg    <= div_quot;
                            pass_reg  <= 1'b1;
                            state_reg <= S_MUL_A;
                        end
                        else
                        begin
                            py_reg    <= div_quot;
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        ovalid_reg <= 1'b1;
                        kind_reg   <= KIND_POSITION;
                        px_reg     <= qx_reg;
                        err_reg    <= 1'b0;
                        state_reg  <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // outputs
    assign out_valid    = ovalid_reg;
    assign event_kind   = kind_reg;
    assign pos_x        = (ovalid_reg && kind_reg == KIND_POSITION) ? px_reg : '0;
    assign pos_y        = (ovalid_reg && kind_reg == KIND_POSITION) ? py_reg : '0;
    assign divide_error = err_reg;

endmodule : touch_calibrate_and_pen_state

`default_nettype wire

/* src/tcps_div.sv */
// tcps_div: iterative signed divider, one quotient bit per cycle
// returns the low bits of the quotient truncated toward zero
// depends on tcps_pkg
`timescale 1ns / 1ps
`default_nettype none

module tcps_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [tcps_pkg::NUM_W-1:0]   num,
    input  logic signed [tcps_pkg::COEF_W-1:0]  den,
    output logic                                done,
    output logic        [tcps_pkg::POS_W-1:0]   quot
);
    import tcps_pkg::*;

    localparam int CNT_W = $clog2(MAG_W + 1);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 neg_reg;
    logic [MAG_W-1:0]     dvd_reg;
    logic [COEF_W-1:0]    dmag_reg;
    logic [COEF_W-1:0]    rem_reg;
    logic [POS_W-1:0]     q_reg;

    logic [NUM_W-1:0]     num_abs;
    logic [COEF_W-1:0]    den_abs;
    logic [COEF_W:0]      shifted;
    logic [COEF_W+1:0]    diff;
    logic                 qbit;
    logic [COEF_W-1:0]    rem_next;

    // operand magnitudes
    assign num_abs = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    assign den_abs = den[COEF_W-1] ? COEF_W'(-den) : COEF_W'(den);

    // restoring step: shift in the next dividend bit and try a subtract
    assign shifted  = {rem_reg, dvd_reg[MAG_W-1]};
    assign diff     = {1'b0, shifted} - {2'b00, dmag_reg};
    assign qbit     = ~diff[COEF_W+1];
    assign rem_next = qbit ? diff[COEF_W-1:0] : shifted[COEF_W-1:0];

    // sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(MAG_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg  <= num[NUM_W-1] ^ den[COEF_W-1];
            dvd_reg  <= num_abs[MAG_W-1:0];
            dmag_reg <= den_abs;
            rem_reg  <= '0;
            q_reg    <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[MAG_W-2:0], 1'b0};
            rem_reg <= rem_next;
            q_reg   <= {q_reg[POS_W-2:0], qbit};
        end
    end

    // sign fix on the low quotient bits
    assign done = done_reg;
    assign quot = neg_reg ? POS_W'(-q_reg) : q_reg;

endmodule : tcps_div

`default_nettype wire
